// ----- sv/scpt_pkg.sv -----
// Shared types and constants of the second-chance page translator.
package scpt_pkg;

    // Field and bus widths fixed by the access and result formats.
    localparam int CFG_W    = 5;
    localparam int VPAGE_W  = 8;
    localparam int OFFS_W   = 12;
    localparam int PADDR_W  = 16;
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 4;

    // Access kind carried in the input tuser.
    localparam logic CMD_WRITE = 1'b1;

    // Per-page flag word: valid, reference, dirty, accessed.
    typedef logic [3:0] t_flags;
    localparam t_flags FLAG_VALID_M  = 4'b0001;
    localparam t_flags FLAG_REF_M    = 4'b0010;
    localparam t_flags FLAG_DIRTY_M  = 4'b0100;
    localparam t_flags FLAG_ACC_M    = 4'b1000;
    localparam t_flags FLAGS_LOADED  = 4'b1011;
    localparam t_flags FLAGS_WRITTEN = 4'b1111;

    // Reset value of the frame count register.
    localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

    // Status of the hand remainder unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_status;

endpackage

// ----- sv/second_chance_page_translate_top.sv -----
// Top level of the second-chance page translator: sequencer, page and frame stores.
// Each request on the slave stream is a read or write access (tuser) to a virtual page and a
// byte offset (tdata); each produces one result on the master stream with the physical
// address, the evicted page (tdata) and the fault, eviction, writeback and swap-in flags
// (tuser). After reset the block runs a clearing pass over the page-flag and frame-owner
// memories before it takes its first request. One request is handled at a time. A hit goes
// from the lookup step straight to the done step. On a fault the hand is first reduced by a
// bit-serial remainder unit (one bit per cycle); then the frame after the hand is checked and
// the clock hand sweeps the frames, where every sweep step waits on one registered read of the
// owner memory and one of the flag memory. A finished result waits in the output register
// while the next request is taken; a result that finds the output register still full holds
// the sequencer in its last step until that register drains.
module second_chance_page_translate_top #(
    parameter int VIRTUAL_PAGES = 256,
    parameter int FRAMES        = 16,
    parameter int PAGE_BYTES    = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Frame count register write.
    input  logic                          i_cfg_wr_en,
    input  logic [scpt_pkg::CFG_W-1:0]    i_cfg_wr_data,
    // Access requests.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata from bit 0: virtual_page[7:0], page_offset[19:8], zero fill[23:20].
    input  logic [scpt_pkg::S_DATA_W-1:0] s_axis_tdata,
    // tuser from bit 0: command.
    input  logic [scpt_pkg::S_USER_W-1:0] s_axis_tuser,
    // Translation results.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata from bit 0: physical_address[15:0], evicted_page[23:16].
    output logic [scpt_pkg::M_DATA_W-1:0] m_axis_tdata,
    // tuser from bit 0: page_fault, evicted, write_back, swap_in.
    output logic [scpt_pkg::M_USER_W-1:0] m_axis_tuser
);
    import scpt_pkg::*;

    localparam int PW    = $clog2(VIRTUAL_PAGES);
    localparam int FW    = $clog2(FRAMES);
    localparam int NW    = $clog2(FRAMES + 1);
    localparam int OW    = $clog2(PAGE_BYTES);
    localparam int CLR_N = (VIRTUAL_PAGES > FRAMES) ? VIRTUAL_PAGES : FRAMES;
    localparam int CW    = $clog2(CLR_N);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_LOOK     = 4'd2;
    localparam logic [3:0] ST_MOD      = 4'd3;
    localparam logic [3:0] ST_NEXT     = 4'd4;
    localparam logic [3:0] ST_NEXT_CHK = 4'd5;
    localparam logic [3:0] ST_OWN_CHK  = 4'd6;
    localparam logic [3:0] ST_FLAG_CHK = 4'd7;
    localparam logic [3:0] ST_LOAD     = 4'd8;
    localparam logic [3:0] ST_DONE     = 4'd9;

    typedef struct packed {
        logic          used;
        logic [PW-1:0] page;
    } t_owner;

    // Page number reduced modulo the page count, one restoring step per bit.
    function automatic logic [VPAGE_W-1:0] f_page_mod(input logic [VPAGE_W-1:0] v);
        logic [VPAGE_W:0] r;
        r = '0;
        for (int i = VPAGE_W - 1; i >= 0; i--) begin
            r = {r[VPAGE_W-1:0], v[i]};
            if (r >= VIRTUAL_PAGES) begin
                r = r - (VPAGE_W+1)'(VIRTUAL_PAGES);
            end
        end
        return r[VPAGE_W-1:0];
    endfunction

    // Offset reduced modulo the page size in the same way.
    function automatic logic [OFFS_W-1:0] f_offs_mod(input logic [OFFS_W-1:0] v);
        logic [OFFS_W:0] r;
        r = '0;
        for (int i = OFFS_W - 1; i >= 0; i--) begin
            r = {r[OFFS_W-1:0], v[i]};
            if (r >= PAGE_BYTES) begin
                r = r - (OFFS_W+1)'(PAGE_BYTES);
            end
        end
        return r[OFFS_W-1:0];
    endfunction

    // Memories.
    t_flags          r_flag_mem  [VIRTUAL_PAGES];
    logic [FW-1:0]   r_frame_mem [VIRTUAL_PAGES];
    t_owner          r_owner_mem [FRAMES];
    t_flags          r_fl_q;
    logic [FW-1:0]   r_fr_q;
    t_owner          r_ow_q;

    // Memory port controls.
    logic            w_fl_we;
    logic [PW-1:0]   w_fl_waddr;
    t_flags          w_fl_wdata;
    logic [PW-1:0]   w_fl_raddr;
    logic            w_fr_we;
    logic            w_ow_we;
    logic [FW-1:0]   w_ow_waddr;
    t_owner          w_ow_wdata;
    logic [FW-1:0]   w_ow_raddr;

    // Control state.
    logic [3:0]       r_state, n_state;
    logic [CW-1:0]    r_clr_cnt, n_clr_cnt;
    logic [FW-1:0]    r_hand, n_hand;
    logic [CFG_W-1:0] r_fiu;
    logic             r_out_valid, n_out_valid;

    // Request and working registers.
    logic             r_cmd, n_cmd;
    logic [PW-1:0]    r_vp, n_vp;
    logic [OW-1:0]    r_off, n_off;
    logic [FW-1:0]    r_frame, n_frame;
    logic [FW-1:0]    r_h, n_h;
    logic [PW-1:0]    r_p, n_p;
    logic [NW-1:0]    r_n, n_n;
    logic             r_fault, n_fault;
    logic             r_ev, n_ev;
    logic [PW-1:0]    r_ev_page, n_ev_page;
    logic             r_wb, n_wb;
    logic             r_swap, n_swap;

    // Output register.
    logic [PADDR_W-1:0] r_o_paddr, n_o_paddr;
    logic [VPAGE_W-1:0] r_o_evpage, n_o_evpage;
    logic               r_o_fault, n_o_fault;
    logic               r_o_ev, n_o_ev;
    logic               r_o_wb, n_o_wb;
    logic               r_o_swap, n_o_swap;

    logic               w_accept;
    logic [PW-1:0]      w_vp_in;
    logic [OW-1:0]      w_off_in;
    logic [NW-1:0]      w_n;
    logic [NW-1:0]      w_h_inc;
    logic [FW-1:0]      w_h_next;
    logic               w_rem_start;
    t_rem_status        w_rem_st;
    logic [NW-1:0]      w_rem;
    logic [PADDR_W-1:0] w_paddr;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_vp_in       = PW'(f_page_mod(s_axis_tdata[VPAGE_W-1:0]));
    assign w_off_in      = OW'(f_offs_mod(s_axis_tdata[VPAGE_W +: OFFS_W]));

    // Active frame count, clamped to the legal range.
    always_comb begin
        if (r_fiu == '0) begin
            w_n = NW'(1);
        end else if (r_fiu > FRAMES) begin
            w_n = NW'(FRAMES);
        end else begin
            w_n = NW'(r_fiu);
        end
    end

    // Hand advance, wrapping at the latched frame count.
    assign w_h_inc  = NW'(r_h) + NW'(1);
    assign w_h_next = (w_h_inc == r_n) ? '0 : FW'(w_h_inc);

    // Frame number times page size plus offset, kept to 16 bits.
    assign w_paddr = PADDR_W'(PADDR_W'(r_frame) * PADDR_W'(PAGE_BYTES)) + PADDR_W'(r_off);

    // Hand reduction unit.
    scpt_rem_unit #(
        .DVD_W (FW),
        .DVS_W (NW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (r_hand),
        .i_divisor  (w_n),
        .o_status   (w_rem_st),
        .o_rem      (w_rem)
    );

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_hand      = r_hand;
        n_cmd       = r_cmd;
        n_vp        = r_vp;
        n_off       = r_off;
        n_frame     = r_frame;
        n_h         = r_h;
        n_p         = r_p;
        n_n         = r_n;
        n_fault     = r_fault;
        n_ev        = r_ev;
        n_ev_page   = r_ev_page;
        n_wb        = r_wb;
        n_swap      = r_swap;
        n_o_paddr   = r_o_paddr;
        n_o_evpage  = r_o_evpage;
        n_o_fault   = r_o_fault;
        n_o_ev      = r_o_ev;
        n_o_wb      = r_o_wb;
        n_o_swap    = r_o_swap;
        n_out_valid = r_out_valid && !m_axis_tready;
        w_rem_start = 1'b0;
        w_fl_we     = 1'b0;
        w_fl_waddr  = r_vp;
        w_fl_wdata  = '0;
        w_fl_raddr  = r_vp;
        w_fr_we     = 1'b0;
        w_ow_we     = 1'b0;
        w_ow_waddr  = r_h;
        w_ow_wdata  = '0;
        w_ow_raddr  = r_h;

        case (r_state)
            ST_CLEAR: begin
                w_fl_we    = (r_clr_cnt < VIRTUAL_PAGES);
                w_fl_waddr = PW'(r_clr_cnt);
                w_ow_we    = (r_clr_cnt < FRAMES);
                w_ow_waddr = FW'(r_clr_cnt);
                n_clr_cnt  = r_clr_cnt + CW'(1);
                if (r_clr_cnt == CW'(CLR_N - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                w_fl_raddr = w_vp_in;
                if (w_accept) begin
                    n_cmd     = s_axis_tuser[0];
                    n_vp      = w_vp_in;
                    n_off     = w_off_in;
                    n_fault   = 1'b0;
                    n_ev      = 1'b0;
                    n_ev_page = '0;
                    n_wb      = 1'b0;
                    n_swap    = 1'b0;
                    n_state   = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if ((r_fl_q & FLAG_VALID_M) != '0) begin
                    // Hit: mark referenced, or fully written.
                    w_fl_we    = 1'b1;
                    w_fl_wdata = (r_cmd == CMD_WRITE) ? FLAGS_WRITTEN : (r_fl_q | FLAG_REF_M);
                    n_frame    = r_fr_q;
                    n_state    = ST_DONE;
                end else begin
                    // Fault: reduce the hand by the active frame count.
                    n_fault     = 1'b1;
                    n_swap      = ((r_fl_q & FLAG_ACC_M) != '0);
                    n_n         = w_n;
                    w_rem_start = 1'b1;
                    n_state     = ST_MOD;
                end
            end
            ST_MOD: begin
                if (w_rem_st.done) begin
                    n_h     = FW'(w_rem);
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                w_ow_raddr = w_h_next;
                n_state    = ST_NEXT_CHK;
            end
            ST_NEXT_CHK: begin
                if (!r_ow_q.used) begin
                    // The frame after the hand is free: take it.
                    n_h     = w_h_next;
                    n_state = ST_LOAD;
                end else begin
                    w_ow_raddr = r_h;
                    n_state    = ST_OWN_CHK;
                end
            end
            ST_OWN_CHK: begin
                if (!r_ow_q.used) begin
                    n_state = ST_LOAD;
                end else begin
                    n_p        = r_ow_q.page;
                    w_fl_raddr = r_ow_q.page;
                    n_state    = ST_FLAG_CHK;
                end
            end
            ST_FLAG_CHK: begin
                w_fl_we    = 1'b1;
                w_fl_waddr = r_p;
                if ((r_fl_q & FLAG_REF_M) != '0) begin
                    // Second chance: clear the reference bit and move on.
                    w_fl_wdata = r_fl_q & ~FLAG_REF_M;
                    n_h        = w_h_next;
                    w_ow_raddr = w_h_next;
                    n_state    = ST_OWN_CHK;
                end else begin
                    // Victim found: drop only its valid bit.
                    w_fl_wdata = r_fl_q & ~FLAG_VALID_M;
                    n_ev       = 1'b1;
                    n_ev_page  = r_p;
                    n_wb       = ((r_fl_q & FLAG_DIRTY_M) != '0);
                    n_state    = ST_LOAD;
                end
            end
            ST_LOAD: begin
                w_fl_we         = 1'b1;
                w_fl_wdata      = (r_cmd == CMD_WRITE) ? FLAGS_WRITTEN : FLAGS_LOADED;
                w_fr_we         = 1'b1;
                w_ow_we         = 1'b1;
                w_ow_wdata.used = 1'b1;
                w_ow_wdata.page = r_vp;
                n_hand          = r_h;
                n_frame         = r_h;
                n_state         = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_o_paddr   = w_paddr;
                    n_o_evpage  = VPAGE_W'(r_ev_page);
                    n_o_fault   = r_fault;
                    n_o_ev      = r_ev;
                    n_o_wb      = r_wb;
                    n_o_swap    = r_swap;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_hand      <= '0;
            r_fiu       <= FRAMES_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_hand      <= n_hand;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_fiu <= i_cfg_wr_data;
            end
        end
    end

    // Working and output payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_vp       <= n_vp;
        r_off      <= n_off;
        r_frame    <= n_frame;
        r_h        <= n_h;
        r_p        <= n_p;
        r_n        <= n_n;
        r_fault    <= n_fault;
        r_ev       <= n_ev;
        r_ev_page  <= n_ev_page;
        r_wb       <= n_wb;
        r_swap     <= n_swap;
        r_o_paddr  <= n_o_paddr;
        r_o_evpage <= n_o_evpage;
        r_o_fault  <= n_o_fault;
        r_o_ev     <= n_o_ev;
        r_o_wb     <= n_o_wb;
        r_o_swap   <= n_o_swap;
    end

    // Page flag memory: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_fl_we) begin
            r_flag_mem[w_fl_waddr] <= w_fl_wdata;
        end
        r_fl_q <= r_flag_mem[w_fl_raddr];
    end

    // Page-to-frame memory, read at the incoming page.
    always_ff @(posedge i_clk) begin
        if (w_fr_we) begin
            r_frame_mem[r_vp] <= r_h;
        end
        r_fr_q <= r_frame_mem[w_vp_in];
    end

    // Frame owner memory.
    always_ff @(posedge i_clk) begin
        if (w_ow_we) begin
            r_owner_mem[w_ow_waddr] <= w_ow_wdata;
        end
        r_ow_q <= r_owner_mem[w_ow_raddr];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_o_evpage, r_o_paddr};
    assign m_axis_tuser  = {r_o_swap, r_o_wb, r_o_ev, r_o_fault};

`ifndef SYNTHESIS
    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_LOOK))
        else $error("Accepted request did not move to the lookup step.");

    a_load_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (NW'(r_h) < r_n))
        else $error("Chosen frame lies beyond the active frame count.");

    a_rem_only_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_MOD) |-> !w_rem_st.busy)
        else $error("Remainder unit busy outside the reduction step.");

    a_evict_needs_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_ev) |-> r_o_fault)
        else $error("Eviction reported without a page fault.");

    a_wb_needs_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_wb) |-> r_o_ev)
        else $error("Writeback reported without an eviction.");
`endif

endmodule

// ----- sv/scpt_rem_unit.sv -----
// Bit-serial remainder unit that reduces the clock hand by the active frame count.
module scpt_rem_unit #(
    parameter int DVD_W = 4,
    parameter int DVS_W = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DVD_W-1:0]      i_dividend,
    input  logic [DVS_W-1:0]      i_divisor,
    output scpt_pkg::t_rem_status o_status,
    output logic [DVS_W-1:0]      o_rem
);
    import scpt_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W:0]   w_shift;

    // Bring down the next dividend bit next to the partial remainder.
    assign w_shift = {r_rem, r_dvd[DVD_W-1]};

    // Step counter: one dividend bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Restoring step: compare and subtract the latched divisor.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            r_dvd <= r_dvd << 1;
            if (w_shift >= {1'b0, r_dvs}) begin
                r_rem <= DVS_W'(w_shift - {1'b0, r_dvs});
            end else begin
                r_rem <= DVS_W'(w_shift);
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_busy && (r_cnt == '0);
    assign o_rem         = r_rem;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_cnt == '0)) |-> (r_rem < r_dvs))
        else $error("Remainder is not below the divisor at completion.");
`endif

endmodule
